// ----- rtl/usd_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package usd_pkg;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_POLICY  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_BIG_CODES    = 2'd0;
	localparam logic [1:0] CFG_XML_CONTROLS = 2'd1;
	localparam logic [1:0] CFG_SURROGATES   = 2'd2;
	localparam logic [1:0] CFG_NONCHARS     = 2'd3;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [30:0] code_point;
		logic [1:0]  status;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic accept_big_codes;
		logic exclude_xml_controls;
		logic accept_surrogates;
		logic accept_noncharacters;
	} cfg_t;

	typedef struct packed {
		logic        open_sequence;
		logic [30:0] accumulated_code;
		logic [2:0]  tails_expected;
		logic [2:0]  tails_taken;
	} dec_state_t;

	// results caused by one byte: err_count errors, then optionally one code
	typedef struct packed {
		logic [2:0]  err_count;
		logic        has_final;
		logic [30:0] code;
		logic [1:0]  status;
	} plan_t;

endpackage

// ----- rtl/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder: input register, state, config, result stage.
//
// Usage:
//   Input channel (in_valid/in_stall/in_item) takes one raw byte per item plus an
//   end-of-buffer flag. Output channel (out_valid/out_stall/out_item) gives code
//   points with a status (ok, invalid, rejected by policy); last_of_run marks the
//   final result caused by one byte. A byte may cause zero to six results.
//   Config: cfg_we writes bit 0 of cfg_data into the policy switch at cfg_index;
//   write only while the decoder is idle.
// Timing:
//   A byte accepted into the input register is decoded and its first result is
//   loaded into the result register. One byte per cycle is sustained while each
//   byte causes at most one result and out_stall is low; a byte with more results
//   holds the input while the single result register plays them out one per cycle.
// Reset: clears the open sequence and all policy switches; no items are pending.
// Stall: a stalled result holds steady; the input register keeps accepting until
//   a byte with results waits behind it, then in_stall rises.
`timescale 1ns / 1ps

module utf8_stream_decoder
	import usd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data
);

	cfg_t       cfg_q;
	dec_state_t st_q;
	dec_state_t st_nxt;
	in_item_t   item_s1;
	logic       valid_s1;
	plan_t      plan;
	logic       nonempty;
	logic       free;
	logic       advance;
	logic       load;
	logic       accept;

	assign nonempty = (plan.err_count != 3'd0) || plan.has_final;
	assign advance  = valid_s1 && (free || !nonempty);
	assign load     = advance && nonempty;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIG_CODES:    cfg_q.accept_big_codes     <= cfg_data;
				CFG_XML_CONTROLS: cfg_q.exclude_xml_controls <= cfg_data;
				CFG_SURROGATES:   cfg_q.accept_surrogates    <= cfg_data;
				CFG_NONCHARS:     cfg_q.accept_noncharacters <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	usd_decode u_decode (
		.st   (st_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.plan (plan)
	);

	usd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.plan      (plan),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/usd_decode.sv -----
// Per-byte decode: next sequence state and the list of results for one byte.
`timescale 1ns / 1ps

module usd_decode
	import usd_pkg::*;
(
	input  dec_state_t st,
	input  cfg_t       cfg,
	input  in_item_t   item,
	output dec_state_t nxt,
	output plan_t      plan
);

	function automatic logic [30:0] min_code(input logic [2:0] tails);
		logic [30:0] m;
		case (tails)
			3'd0: m = 31'h0000_0000;
			3'd1: m = 31'h0000_0080;
			3'd2: m = 31'h0000_0800;
			3'd3: m = 31'h0001_0000;
			3'd4: m = 31'h0020_0000;
			3'd5: m = 31'h0400_0000;
			default: m = '0;
		endcase
		return m;
	endfunction

	logic [7:0]  b;
	logic        is_tail;
	logic        stray;
	logic [2:0]  lead_tails;
	logic [30:0] acc_n;
	logic [2:0]  taken_n;
	logic        do_lead;
	logic        do_fin;
	logic [30:0] fin_code;
	logic [2:0]  fin_tails;
	logic [2:0]  errs;
	logic        overlong;
	logic [1:0]  fin_status;

	assign b       = item.byte_value;
	assign is_tail = (b[7:6] == 2'b10);
	assign stray   = is_tail || (b >= 8'hFE);
	assign acc_n   = {st.accumulated_code[24:0], b[5:0]};
	assign taken_n = st.tails_taken + 3'd1;

	always_comb begin
		if (b >= 8'hFC) begin
			lead_tails = 3'd5;
		end else if (b >= 8'hF8) begin
			lead_tails = 3'd4;
		end else if (b >= 8'hF0) begin
			lead_tails = 3'd3;
		end else if (b >= 8'hE0) begin
			lead_tails = 3'd2;
		end else begin
			lead_tails = 3'd1;
		end
	end

	// sequence tracking
	always_comb begin
		nxt       = st;
		errs      = '0;
		do_lead   = 1'b0;
		do_fin    = 1'b0;
		fin_code  = '0;
		fin_tails = '0;
		if (st.open_sequence) begin
			if (is_tail) begin
				if (taken_n >= st.tails_expected) begin
					do_fin    = 1'b1;
					fin_code  = acc_n;
					fin_tails = st.tails_expected;
					nxt       = '0;
				end else begin
					nxt.accumulated_code = acc_n;
					nxt.tails_taken      = taken_n;
				end
			end else begin
				// broken: one error for the lead, one per tail taken, then retry as lead
				errs    = 3'd1 + st.tails_taken;
				nxt     = '0;
				do_lead = 1'b1;
			end
		end else begin
			do_lead = 1'b1;
		end

		if (do_lead) begin
			if (stray) begin
				errs = errs + 3'd1;
			end else if (!b[7]) begin
				do_fin    = 1'b1;
				fin_code  = {23'd0, b};
				fin_tails = 3'd0;
			end else begin
				nxt.open_sequence    = 1'b1;
				nxt.accumulated_code = {23'd0, b & (8'h3F >> lead_tails)};
				nxt.tails_expected   = lead_tails;
				nxt.tails_taken      = 3'd0;
			end
		end

		// end of buffer closes whatever is still open
		if (nxt.open_sequence && item.end_of_buffer) begin
			errs = errs + 3'd1 + nxt.tails_taken;
			nxt  = '0;
		end
	end

	// overlong and policy checks on a completed code
	always_comb begin
		overlong   = (fin_tails > 3'd5) || (fin_code < min_code(fin_tails));
		fin_status = STATUS_OK;
		if (fin_code > 31'h0010_FFFF && !cfg.accept_big_codes) begin
			fin_status = STATUS_POLICY;
		end
		if (fin_code < 31'h20 && fin_code != 31'h9 && fin_code != 31'hA &&
				fin_code != 31'hD && cfg.exclude_xml_controls) begin
			fin_status = STATUS_POLICY;
		end
		if (fin_code >= 31'hD800 && fin_code <= 31'hDFFF && !cfg.accept_surrogates) begin
			fin_status = STATUS_POLICY;
		end
		if ((fin_code == 31'hFFFE || fin_code == 31'hFFFF) && !cfg.accept_noncharacters) begin
			fin_status = STATUS_POLICY;
		end
	end

	always_comb begin
		plan = '0;
		plan.err_count = errs;
		if (do_fin) begin
			if (overlong) begin
				plan.err_count = errs + 3'd1;
			end else begin
				plan.has_final = 1'b1;
				plan.code      = fin_code;
				plan.status    = fin_status;
			end
		end
	end

endmodule

// ----- rtl/usd_emit.sv -----
// Result register: plays out one byte's results, one item per cycle while out_stall is low.
`timescale 1ns / 1ps

module usd_emit
	import usd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  plan_t     plan,
	output logic      free,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	plan_t plan_q;
	logic  valid_q;
	logic  last;
	logic  pop;

	assign last = (plan_q.err_count == 3'd0) ||
		(plan_q.err_count == 3'd1 && !plan_q.has_final);
	assign pop  = valid_q && !out_stall;
	assign free = !valid_q || (pop && last);

	always_comb begin
		out_item.last_of_run = last;
		if (plan_q.err_count != 3'd0) begin
			out_item.code_point = '0;
			out_item.status     = STATUS_INVALID;
		end else begin
			out_item.code_point = plan_q.code;
			out_item.status     = plan_q.status;
		end
	end

	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop && last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plan_q <= plan;
		end else if (pop && plan_q.err_count != 3'd0) begin
			plan_q.err_count <= plan_q.err_count - 3'd1;
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load && valid_q |-> pop && last)
		else $error("plan loaded over unfinished results");

	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (plan.err_count != 3'd0 || plan.has_final))
		else $error("empty plan loaded");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !last |=> valid_q)
		else $error("results dropped before last of run");

	a_err_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop && plan_q.err_count != 3'd0 && !load |=>
		plan_q.err_count == $past(plan_q.err_count) - 3'd1)
		else $error("error count did not step down");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> plan_q.err_count <= 3'd6)
		else $error("error count out of range");
`endif

endmodule

// ----- verif/tb_utf8_stream_decoder.sv -----
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
	import usd_pkg::*;

	typedef in_item_t item_q_t[$];

	// code points that sit on a policy or length boundary
	localparam int unsigned EDGE_CODES [17] = '{
		32'h0, 32'h9, 32'hA, 32'hD, 32'h1F, 32'h20, 32'hD7FF, 32'hD800, 32'hDFFF, 32'hE000,
		32'hFFFD, 32'hFFFE, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000, 32'h7FFFFFFF
	};

	class code_point_scoreboard;
		cfg_t        policy;
		logic        seq_open;
		logic [30:0] seq_code;
		logic [2:0]  tails_due;
		logic [2:0]  tails_seen;
		out_item_t   byte_results[$];
		out_item_t   pending_codes[$];
		int          mismatches;
		int          bytes_taken;
		int          seen_ok;
		int          seen_invalid;
		int          seen_policy;

		function new();
			policy = '0;
			seq_open = 1'b0;
			seq_code = '0;
			tails_due = '0;
			tails_seen = '0;
			mismatches = 0;
			bytes_taken = 0;
			seen_ok = 0;
			seen_invalid = 0;
			seen_policy = 0;
		endfunction

		function void emit(logic [30:0] code, logic [1:0] status);
			out_item_t r;
			r.code_point = code;
			r.status = status;
			r.last_of_run = 1'b0;
			byte_results.push_back(r);
		endfunction

		function void finish_code(logic [30:0] code, logic [2:0] tails);
			logic [30:0] min_code;
			logic [1:0]  status;
			case (tails)
				3'd0: min_code = 31'h0;
				3'd1: min_code = 31'h80;
				3'd2: min_code = 31'h800;
				3'd3: min_code = 31'h10000;
				3'd4: min_code = 31'h200000;
				default: min_code = 31'h4000000;
			endcase
			if (code < min_code) begin
				emit('0, STATUS_INVALID);
				return;
			end
			status = STATUS_OK;
			if (code > 31'h10FFFF && !policy.accept_big_codes)
				status = STATUS_POLICY;
			if (code < 31'h20 && code != 31'h9 && code != 31'hA && code != 31'hD &&
					policy.exclude_xml_controls)
				status = STATUS_POLICY;
			if (code >= 31'hD800 && code <= 31'hDFFF && !policy.accept_surrogates)
				status = STATUS_POLICY;
			if ((code == 31'hFFFE || code == 31'hFFFF) && !policy.accept_noncharacters)
				status = STATUS_POLICY;
			emit(code, status);
		endfunction

		// one error for the lead, one per tail already taken
		function void close_sequence();
			emit('0, STATUS_INVALID);
			repeat (tails_seen) emit('0, STATUS_INVALID);
			seq_open = 1'b0;
			seq_code = '0;
			tails_due = '0;
			tails_seen = '0;
		endfunction

		function void take_lead(logic [7:0] b);
			logic [2:0] t;
			if (b[7:6] == 2'b10 || b >= 8'hFE) begin
				emit('0, STATUS_INVALID);
			end else if (!b[7]) begin
				finish_code({23'd0, b}, 3'd0);
			end else begin
				if (b >= 8'hFC)
					t = 3'd5;
				else if (b >= 8'hF8)
					t = 3'd4;
				else if (b >= 8'hF0)
					t = 3'd3;
				else if (b >= 8'hE0)
					t = 3'd2;
				else
					t = 3'd1;
				seq_code = {23'd0, b & (8'h3F >> t)};
				tails_due = t;
				tails_seen = '0;
				seq_open = 1'b1;
			end
		endfunction

		function void take_byte(in_item_t it);
			logic [7:0] b;
			out_item_t  tail;
			b = it.byte_value;
			byte_results.delete();
			bytes_taken++;
			if (seq_open) begin
				if (b[7:6] == 2'b10) begin
					seq_code = {seq_code[24:0], b[5:0]};
					tails_seen++;
					if (tails_seen >= tails_due) begin
						finish_code(seq_code, tails_due);
						seq_open = 1'b0;
						seq_code = '0;
						tails_due = '0;
						tails_seen = '0;
					end
				end else begin
					close_sequence();
					take_lead(b);
				end
			end else begin
				take_lead(b);
			end
			if (seq_open && it.end_of_buffer)
				close_sequence();
			if (byte_results.size() != 0) begin
				tail = byte_results.pop_back();
				tail.last_of_run = 1'b1;
				byte_results.push_back(tail);
			end
			foreach (byte_results[i])
				pending_codes.push_back(byte_results[i]);
		endfunction

		function void check_code(out_item_t got);
			out_item_t want;
			if (pending_codes.size() == 0) begin
				$error("result with no byte pending: code_point %h status %0d",
					got.code_point, got.status);
				mismatches++;
				return;
			end
			want = pending_codes.pop_front();
			case (want.status)
				STATUS_OK: seen_ok++;
				STATUS_INVALID: seen_invalid++;
				default: seen_policy++;
			endcase
			if (got.code_point !== want.code_point) begin
				$error("code_point: expected %h, got %h", want.code_point, got.code_point);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_item;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic       cfg_data;

	code_point_scoreboard sb;
	logic quiet;
	int   n_settings;

	utf8_stream_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_code(out_item);
	end

	function automatic in_item_t mk_byte(logic [7:0] b, logic eob);
		in_item_t it;
		it.byte_value = b;
		it.end_of_buffer = eob;
		return it;
	endfunction

	function automatic int min_len(int unsigned code);
		if (code < 32'h80)
			return 1;
		if (code < 32'h800)
			return 2;
		if (code < 32'h10000)
			return 3;
		if (code < 32'h200000)
			return 4;
		if (code < 32'h4000000)
			return 5;
		return 6;
	endfunction

	function automatic item_q_t encode(int unsigned code, int len);
		item_q_t    q;
		in_item_t   it;
		logic [7:0] prefix;
		it.end_of_buffer = 1'b0;
		if (len == 1) begin
			it.byte_value = {1'b0, code[6:0]};
			q.push_back(it);
		end else begin
			prefix = 8'hFF << (8 - len);
			it.byte_value = prefix | 8'((code >> (6 * (len - 1))) & (32'h7F >> len));
			q.push_back(it);
			for (int i = len - 2; i >= 0; i--) begin
				it.byte_value = 8'h80 | 8'((code >> (6 * i)) & 32'h3F);
				q.push_back(it);
			end
		end
		return q;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_byte(it);
		@(negedge clk);
	endtask

	// hold off input until every pending result is back, plus the decode latency
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_codes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_policy(input cfg_t p);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BIG_CODES;
		cfg_data <= p.accept_big_codes;
		@(negedge clk);
		cfg_index <= CFG_XML_CONTROLS;
		cfg_data <= p.exclude_xml_controls;
		@(negedge clk);
		cfg_index <= CFG_SURROGATES;
		cfg_data <= p.accept_surrogates;
		@(negedge clk);
		cfg_index <= CFG_NONCHARS;
		cfg_data <= p.accept_noncharacters;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.policy = p;
		n_settings++;
	endtask

	task automatic run_phase(input cfg_t p, input int budget);
		int          sent;
		int          len;
		int          at;
		int unsigned code;
		item_q_t     seq;
		in_item_t    junk;
		drain();
		apply_policy(p);
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 9))
				0: code = $urandom_range(0, 32'h7F);
				1: code = EDGE_CODES[$urandom_range(0, 16)];
				2: code = $urandom_range(32'h80, 32'h7FF);
				3: code = $urandom_range(32'h800, 32'hFFFF);
				4: code = $urandom_range(32'h10000, 32'h10FFFF);
				5: code = $urandom_range(32'h110000, 32'h1FFFFF);
				6: code = $urandom_range(32'h200000, 32'h3FFFFFF);
				7: code = $urandom_range(32'h4000000, 32'h7FFFFFFF);
				8: code = $urandom_range(32'hD800, 32'hDFFF);
				default: code = $urandom() >> $urandom_range(1, 31);
			endcase
			len = min_len(code);
			// occasionally an overlong form
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(len, 6);
			seq = encode(code, len);
			case ($urandom_range(0, 9))
				0: begin
					// cut short; the next lead breaks it
					if (seq.size() > 1)
						repeat ($urandom_range(1, seq.size() - 1)) void'(seq.pop_back());
				end
				1: begin
					junk = mk_byte(8'($urandom_range(0, 255)), 1'b0);
					seq.insert($urandom_range(0, seq.size()), junk);
				end
				2: begin
					at = $urandom_range(0, seq.size() - 1);
					junk = seq[at];
					junk.end_of_buffer = 1'b1;
					seq[at] = junk;
				end
				3: begin
					seq.delete();
					repeat ($urandom_range(1, 3))
						seq.push_back(mk_byte(8'($urandom_range(0, 255)),
							$urandom_range(0, 3) == 0));
				end
				default: ;
			endcase
			if ($urandom_range(0, 7) == 0) begin
				junk = seq.pop_back();
				junk.end_of_buffer = 1'b1;
				seq.push_back(junk);
			end
			foreach (seq[i])
				send_byte(seq[i]);
			sent += seq.size();
		end
	endtask

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						n = $urandom_range(1, 17);
						out_stall <= 1'b1;
						repeat (n) @(negedge clk);
						out_stall <= 1'b0;
					end
					1: begin
						out_stall <= 1'b0;
						repeat ($urandom_range(20, 60)) @(negedge clk);
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		cfg_t mix;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BIG_CODES;
		cfg_data = 1'b0;
		quiet = 1'b0;
		n_settings = 0;
		sb = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apply_policy('0);

		// single bytes: NUL, top ASCII, stray tail, invalid lead
		send_byte(mk_byte(8'h00, 1'b0));
		send_byte(mk_byte(8'h7F, 1'b0));
		send_byte(mk_byte(8'h80, 1'b0));
		send_byte(mk_byte(8'hFF, 1'b0));
		// overlong NUL
		send_byte(mk_byte(8'hC0, 1'b0));
		send_byte(mk_byte(8'h80, 1'b0));
		// surrogate, then noncharacter
		send_byte(mk_byte(8'hED, 1'b0));
		send_byte(mk_byte(8'hA0, 1'b0));
		send_byte(mk_byte(8'h80, 1'b0));
		send_byte(mk_byte(8'hEF, 1'b0));
		send_byte(mk_byte(8'hBF, 1'b0));
		send_byte(mk_byte(8'hBF, 1'b0));
		// largest code, six bytes
		send_byte(mk_byte(8'hFD, 1'b0));
		repeat (5) send_byte(mk_byte(8'hBF, 1'b0));
		// breaking byte after one tail, then replayed as a lead
		send_byte(mk_byte(8'hE2, 1'b0));
		send_byte(mk_byte(8'h82, 1'b0));
		send_byte(mk_byte(8'h41, 1'b0));
		// four tails taken, then 0xFE: six errors from one byte
		send_byte(mk_byte(8'hFC, 1'b0));
		repeat (4) send_byte(mk_byte(8'h80, 1'b0));
		send_byte(mk_byte(8'hFE, 1'b0));
		// buffer ends inside a sequence
		send_byte(mk_byte(8'hF4, 1'b0));
		send_byte(mk_byte(8'h90, 1'b1));

		run_phase(cfg_t'(4'b1111), 20);
		run_phase(cfg_t'(4'($urandom_range(0, 15))), 15);
		run_phase(cfg_t'(4'($urandom_range(0, 15))), 15);
		quiet = 1'b1;
		mix = cfg_t'(4'($urandom_range(0, 15)));
		mix.exclude_xml_controls = 1'b1;
		run_phase(mix, 20);

		drain();
		repeat (8) @(negedge clk);
		$display("Run covered %0d bytes across %0d policy settings, %0d results checked",
			sb.bytes_taken, n_settings, sb.seen_ok + sb.seen_invalid + sb.seen_policy);
		$display("Results by status: %0d ok, %0d invalid, %0d rejected by policy",
			sb.seen_ok, sb.seen_invalid, sb.seen_policy);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
